/* hw/rtl/adc_csa_pkg.sv */
// shared types and constants for the adc channel scale and average core
`timescale 1ns / 1ps

package adc_csa_pkg;

    localparam int CHAN_W          = 5;
    localparam int ADC_BITS        = 12;
    localparam int MV_W            = 16;
    localparam int SCALED_CHANNELS = 12;
    localparam int HIGH_GAIN_LAST  = 9;

    localparam int FULL_SCALE_MV   = 3300;
    localparam int ADC_MAX         = (2 ** ADC_BITS) - 1;
    localparam int DIV_LOW         = 24;
    localparam int GAIN_EQUAL      = 24 + 24;
    localparam int GAIN_HIGH       = 330 + 24;
    localparam int AVG_KEEP        = 9;
    localparam int AVG_DIV         = 10;

    // scale factor and product widths
    localparam int K_W             = 21;
    localparam logic [K_W-1:0] K_EQUAL = K_W'(FULL_SCALE_MV * GAIN_EQUAL);
    localparam logic [K_W-1:0] K_HIGH  = K_W'(FULL_SCALE_MV * GAIN_HIGH);
    localparam logic [K_W-1:0] K_NONE  = K_W'(FULL_SCALE_MV);
    localparam int PROD_W          = ADC_BITS + K_W;
    localparam int QSUM_W          = PROD_W + 1;
    localparam int Q0_W            = QSUM_W - ADC_BITS;
    localparam int Q_W             = PROD_W - ADC_BITS;
    localparam int REM_W           = ADC_BITS + 1;

    // divide by 24 as shift by 3 then reciprocal multiply by 1/3
    localparam int LOW_SHIFT       = 3;
    localparam int LOW_ODD         = DIV_LOW >> LOW_SHIFT;
    localparam int V_W             = Q_W - LOW_SHIFT;
    localparam int DIV3_SHIFT      = 20;
    localparam int DIV3_MUL        = ((2 ** DIV3_SHIFT) + LOW_ODD - 1) / LOW_ODD;
    localparam int DIV3_PW         = V_W + DIV3_SHIFT;

    // average update, divide by 10 as reciprocal multiply
    localparam int SUM_W           = 20;
    localparam int DIV10_SHIFT     = 22;
    localparam int DIV10_MUL       = ((2 ** DIV10_SHIFT) + AVG_DIV - 1) / AVG_DIV;
    localparam int P10_W           = SUM_W + DIV10_SHIFT;

    typedef logic [CHAN_W-1:0]   chan_t;
    typedef logic [ADC_BITS-1:0] sample_t;
    typedef logic [MV_W-1:0]     mv_t;

    typedef struct packed {
        chan_t chan;
        mv_t   mv;
    } scale_beat_t;

endpackage

/* hw/rtl/adc_csa_scale.sv */
// pipelined conversion of a raw sample to millivolts per channel class
`timescale 1ns / 1ps

module adc_csa_scale (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  adc_csa_pkg::chan_t        s_chan,
    input  adc_csa_pkg::sample_t      s_sample,
    output logic                      m_valid,
    input  logic                      m_ready,
    output adc_csa_pkg::scale_beat_t  m_beat
);
    import adc_csa_pkg::*;

    logic              a_valid_reg;
    chan_t             a_chan_reg;
    sample_t           a_sample_reg;

    logic              b_valid_reg;
    chan_t             b_chan_reg;
    logic [PROD_W-1:0] b_prod_reg;
    logic [PROD_W-1:0] b_prod_next;

    logic              c_valid_reg;
    chan_t             c_chan_reg;
    logic [PROD_W-1:0] c_prod_reg;
    logic [Q0_W-1:0]   c_q0_reg;
    logic [Q0_W-1:0]   c_q0_next;

    logic              d_valid_reg;
    chan_t             d_chan_reg;
    logic [Q_W-1:0]    d_q_reg;
    logic [Q_W-1:0]    d_q_next;

    logic              e_valid_reg;
    scale_beat_t       e_beat_reg;
    scale_beat_t       e_beat_next;

    logic              load_a, load_b, load_c, load_d, load_e;

    logic [K_W-1:0]     k_sel;
    logic [QSUM_W-1:0]  q_sum;
    logic [QSUM_W-1:0]  rem_full;
    logic [REM_W-1:0]   rem_low;
    logic [Q0_W-1:0]    q_fixed;
    logic [V_W-1:0]     v_div8;
    logic [DIV3_PW-1:0] div3_prod;

    // stall chain, a stage loads when empty or when it drains
    assign load_e  = !e_valid_reg || m_ready;
    assign load_d  = !d_valid_reg || load_e;
    assign load_c  = !c_valid_reg || load_d;
    assign load_b  = !b_valid_reg || load_c;
    assign load_a  = !a_valid_reg || load_b;
    assign s_ready = load_a;
    assign m_valid = e_valid_reg;
    assign m_beat  = e_beat_reg;

    // gain select and multiply
    always_comb begin
        if (a_chan_reg == '0) begin
            k_sel = K_EQUAL;
        end else if (a_chan_reg <= chan_t'(HIGH_GAIN_LAST)) begin
            k_sel = K_HIGH;
        end else begin
            k_sel = K_NONE;
        end
    end
    assign b_prod_next = PROD_W'(a_sample_reg) * PROD_W'(k_sel);

    // divide by 4095, estimate then one correction step
    assign q_sum     = QSUM_W'(b_prod_reg) + QSUM_W'(b_prod_reg >> ADC_BITS)
                     + QSUM_W'(b_prod_reg >> (2 * ADC_BITS));
    assign c_q0_next = q_sum[QSUM_W-1:ADC_BITS];

    assign rem_full  = QSUM_W'(c_prod_reg) - (QSUM_W'(c_q0_reg) << ADC_BITS)
                     + QSUM_W'(c_q0_reg);
    assign rem_low   = rem_full[REM_W-1:0];
    assign q_fixed   = (rem_low >= REM_W'(ADC_MAX)) ? c_q0_reg + Q0_W'(1) : c_q0_reg;
    assign d_q_next  = q_fixed[Q_W-1:0];

    // divide by 24 for divided channels
    assign v_div8    = d_q_reg[Q_W-1:LOW_SHIFT];
    assign div3_prod = DIV3_PW'(v_div8) * DIV3_PW'(DIV3_MUL);

    always_comb begin
        e_beat_next.chan = d_chan_reg;
        if (d_chan_reg <= chan_t'(HIGH_GAIN_LAST)) begin
            e_beat_next.mv = div3_prod[DIV3_SHIFT +: MV_W];
        end else begin
            e_beat_next.mv = d_q_reg[MV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else begin
            if (load_a) begin
                a_valid_reg <= s_valid;
            end
            if (load_b) begin
                b_valid_reg <= a_valid_reg;
            end
            if (load_c) begin
                c_valid_reg <= b_valid_reg;
            end
            if (load_d) begin
                d_valid_reg <= c_valid_reg;
            end
            if (load_e) begin
                e_valid_reg <= d_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_a) begin
            a_chan_reg   <= s_chan;
            a_sample_reg <= s_sample;
        end
        if (load_b) begin
            b_chan_reg <= a_chan_reg;
            b_prod_reg <= b_prod_next;
        end
        if (load_c) begin
            c_chan_reg <= b_chan_reg;
            c_prod_reg <= b_prod_reg;
            c_q0_reg   <= c_q0_next;
        end
        if (load_d) begin
            d_chan_reg <= c_chan_reg;
            d_q_reg    <= d_q_next;
        end
        if (load_e) begin
            e_beat_reg <= e_beat_next;
        end
    end

endmodule

/* hw/rtl/adc_csa_average.sv */
// per-channel running average store, update and result register
`timescale 1ns / 1ps

module adc_csa_average #(
    parameter int NUM_CHANNELS = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  adc_csa_pkg::scale_beat_t  s_beat,
    output logic                      m_valid,
    input  logic                      m_ready,
    output adc_csa_pkg::chan_t        m_chan,
    output logic                      m_known,
    output adc_csa_pkg::mv_t          m_mv,
    output adc_csa_pkg::mv_t          m_avg
);
    import adc_csa_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [CHAN_W:0] NUM_LIM = (CHAN_W + 1)'(NUM_CHANNELS);

    mv_t               avg_reg [NUM_CHANNELS];
    logic              out_valid_reg;
    chan_t             out_chan_reg;
    logic              out_known_reg;
    mv_t               out_mv_reg;
    mv_t               out_avg_reg;

    logic              accept;
    logic              known;
    logic [IDX_W-1:0]  idx;
    mv_t               avg_old;
    logic [SUM_W-1:0]  avg_sum;
    logic [P10_W-1:0]  div10_prod;
    mv_t               avg_next;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign known   = (s_beat.chan < chan_t'(SCALED_CHANNELS))
                  && ({1'b0, s_beat.chan} < NUM_LIM);
    assign idx     = s_beat.chan[IDX_W-1:0];
    assign avg_old = avg_reg[idx];

    // (avg * 9 + mv) / 10
    assign avg_sum    = SUM_W'(avg_old) * SUM_W'(AVG_KEEP) + SUM_W'(s_beat.mv);
    assign div10_prod = P10_W'(avg_sum) * P10_W'(DIV10_MUL);
    assign avg_next   = div10_prod[DIV10_SHIFT +: MV_W];

    assign m_valid = out_valid_reg;
    assign m_chan  = out_chan_reg;
    assign m_known = out_known_reg;
    assign m_mv    = out_mv_reg;
    assign m_avg   = out_avg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                avg_reg[i] <= '0;
            end
        end else begin
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (accept && known) begin
                avg_reg[idx] <= avg_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_chan_reg  <= s_beat.chan;
            out_known_reg <= known;
            out_mv_reg    <= known ? s_beat.mv : '0;
            out_avg_reg   <= known ? avg_next : '0;
        end
    end

endmodule

/* hw/rtl/adc_channel_scale_and_average_core.sv */
// top level: adc sample scaling to millivolts with per-channel running average
// an accepted input beat passes scale registers a to e and the average result register before its result beat on m_axis
// throughput: one beat per cycle, limited only by the result side tready
// the pipeline stalls as a whole from the result register back to s_axis_tready
// reset: aresetn low empties the pipeline and clears every channel average to zero
`timescale 1ns / 1ps

module adc_channel_scale_and_average_core #(
    parameter int NUM_CHANNELS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] sample, [15:12] zero
    input  logic [4:0]  s_axis_tuser,   // [4:0] channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] millivolts, [31:16] average_mv
    output logic [5:0]  m_axis_tuser    // [4:0] channel_echo, [5] known_channel
);
    import adc_csa_pkg::*;

    logic        mid_valid;
    logic        mid_ready;
    scale_beat_t mid_beat;

    chan_t       res_chan;
    logic        res_known;
    mv_t         res_mv;
    mv_t         res_avg;

    adc_csa_scale u_scale (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_axis_tvalid),
        .s_ready  (s_axis_tready),
        .s_chan   (s_axis_tuser[CHAN_W-1:0]),
        .s_sample (s_axis_tdata[ADC_BITS-1:0]),
        .m_valid  (mid_valid),
        .m_ready  (mid_ready),
        .m_beat   (mid_beat)
    );

    adc_csa_average #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_average (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (mid_valid),
        .s_ready  (mid_ready),
        .s_beat   (mid_beat),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_chan   (res_chan),
        .m_known  (res_known),
        .m_mv     (res_mv),
        .m_avg    (res_avg)
    );

    assign m_axis_tdata = {res_avg, res_mv};
    assign m_axis_tuser = {res_known, res_chan};

endmodule

/* tb/sv/adc_channel_scale_and_average_core_test.sv */
// testbench for the adc channel scale and average core: directed table, random beats, predictor
`timescale 1ns / 1ps

module adc_channel_scale_and_average_core_test;

    import adc_csa_pkg::*;

    localparam int NUM_CHANNELS  = 12;
    localparam int RANDOM_BEATS  = 1926;
    localparam int IDLE_PERCENT  = 23;
    localparam int PIPE_LATENCY  = 6;
    localparam int N_DIRECTED    = 24;

    typedef struct packed {
        chan_t chan;
        logic  known;
        mv_t   mv;
        mv_t   avg;
    } reading_t;

    typedef struct packed {
        chan_t   chan;
        sample_t sample;
        logic    typed;
        logic    known;
        mv_t     mv;
        mv_t     avg;
    } stim_row_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [4:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [5:0]  m_axis_tuser;

    mv_t      channel_avg [NUM_CHANNELS];
    reading_t pending_readings [$];
    int       mismatch_count = 0;
    bit       steady         = 1'b0;

    // chan, sample, typed, known, millivolts, average
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{5'd0,  12'd0,     1'b1, 1'b1, 16'd0,     16'd0},
        '{5'd0,  12'd4095,  1'b1, 1'b1, 16'd6600,  16'd660},
        '{5'd5,  12'd4095,  1'b1, 1'b1, 16'd48675, 16'd4867},
        '{5'd10, 12'd4095,  1'b1, 1'b1, 16'd3300,  16'd330},
        '{5'd11, 12'd0,     1'b1, 1'b1, 16'd0,     16'd0},
        '{5'd12, 12'd4095,  1'b1, 1'b0, 16'd0,     16'd0},
        '{5'd31, 12'd4095,  1'b1, 1'b0, 16'd0,     16'd0},
        '{5'd31, 12'd0,     1'b1, 1'b0, 16'd0,     16'd0},
        '{5'd1,  12'd1,     1'b0, 1'b0, 16'd0,     16'd0},
        '{5'd9,  12'd2048,  1'b0, 1'b0, 16'd0,     16'd0},
        '{5'd0,  12'd1,     1'b0, 1'b0, 16'd0,     16'd0},
        '{5'd10, 12'd1,     1'b0, 1'b0, 16'd0,     16'd0},
        '{5'd11, 12'd4095,  1'b0, 1'b0, 16'd0,     16'd0},
        '{5'd9,  12'd4095,  1'b0, 1'b0, 16'd0,     16'd0},
        '{5'd9,  12'd4095,  1'b0, 1'b0, 16'd0,     16'd0},
        '{5'd9,  12'd4095,  1'b0, 1'b0, 16'd0,     16'd0},
        '{5'd9,  12'd4095,  1'b0, 1'b0, 16'd0,     16'd0},
        '{5'd2,  12'hAAA,   1'b0, 1'b0, 16'd0,     16'd0},
        '{5'd3,  12'h555,   1'b0, 1'b0, 16'd0,     16'd0},
        '{5'd16, 12'hFFF,   1'b0, 1'b0, 16'd0,     16'd0},
        '{5'd7,  12'd0,     1'b0, 1'b0, 16'd0,     16'd0},
        '{5'd5,  12'd4095,  1'b0, 1'b0, 16'd0,     16'd0},
        '{5'd4,  12'd1,     1'b0, 1'b0, 16'd0,     16'd0},
        '{5'd8,  12'd4094,  1'b0, 1'b0, 16'd0,     16'd0}
    };

    adc_channel_scale_and_average_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [11:0] sample, [15:12] zero
        .s_axis_tuser  (s_axis_tuser),    // [4:0] channel
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [15:0] millivolts, [31:16] average_mv
        .m_axis_tuser  (m_axis_tuser)     // [4:0] channel_echo, [5] known_channel
    );

    always #10 aclk = ~aclk;

    function automatic reading_t predict_reading(chan_t chan, sample_t sample);
        longint unsigned scaled;
        longint unsigned blended;
        reading_t        r;
        r.chan  = chan;
        r.known = 1'b0;
        r.mv    = '0;
        r.avg   = '0;
        if (chan < SCALED_CHANNELS && chan < NUM_CHANNELS) begin
            if (chan == 0) begin
                scaled = longint'(FULL_SCALE_MV) * sample * GAIN_EQUAL / ADC_MAX / DIV_LOW;
            end else if (chan <= HIGH_GAIN_LAST) begin
                scaled = longint'(FULL_SCALE_MV) * sample * GAIN_HIGH / ADC_MAX / DIV_LOW;
            end else begin
                scaled = longint'(FULL_SCALE_MV) * sample / ADC_MAX;
            end
            r.known = 1'b1;
            r.mv    = mv_t'(scaled);
            blended = (longint'(channel_avg[chan]) * AVG_KEEP + r.mv) / AVG_DIV;
            r.avg   = mv_t'(blended);
            channel_avg[chan] = r.avg;
        end
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_sample(chan_t chan, sample_t sample, stim_row_t row);
        reading_t predicted;
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, sample};
        s_axis_tuser  <= chan;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predicted = predict_reading(chan, sample);
        if (row.typed) begin
            predicted.known = row.known;
            predicted.mv    = row.mv;
            predicted.avg   = row.avg;
        end
        pending_readings.push_back(predicted);
        @(negedge aclk);
    endtask

    task automatic drain_readings();
        s_axis_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_readings.size() != 0) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_readings.size() == 0) begin
                $error("result beat with nothing expected: tuser %h tdata %h",
                       m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_readings.pop_front();
                if (m_axis_tuser[4:0] !== want.chan) begin
                    $error("channel_echo: expected %0d, got %0d", want.chan, m_axis_tuser[4:0]);
                    mismatch_count++;
                end
                if (m_axis_tuser[5] !== want.known) begin
                    $error("known_channel: expected %0d, got %0d", want.known, m_axis_tuser[5]);
                    mismatch_count++;
                end
                if (m_axis_tdata[15:0] !== want.mv) begin
                    $error("millivolts: expected %0d, got %0d", want.mv, m_axis_tdata[15:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[31:16] !== want.avg) begin
                    $error("average_mv: expected %0d, got %0d", want.avg, m_axis_tdata[31:16]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #4_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        stim_row_t blank;
        chan_t     chan;
        sample_t   sample;
        chan_t     burst_chan;
        int        burst_left;
        int        burst_level;
        blank      = '0;
        burst_chan = '0;
        burst_left = 0;
        burst_level = 0;
        foreach (channel_avg[i]) channel_avg[i] = '0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i]) begin
            send_sample(directed_rows[i].chan, directed_rows[i].sample, directed_rows[i]);
        end
        drain_readings();

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            steady = (n >= 700 && n < 1000);
            if (n == 1400) drain_readings();
            if (burst_left == 0 && $urandom_range(19) == 0) begin
                burst_chan  = chan_t'($urandom_range(SCALED_CHANNELS - 1));
                burst_left  = $urandom_range(30, 8);
                burst_level = $urandom_range(4095);
            end
            if (burst_left > 0) begin
                chan   = burst_chan;
                sample = sample_t'((burst_level + $urandom_range(200)) % 4096);
                burst_left--;
            end else begin
                if ($urandom_range(99) < 85) begin
                    chan = chan_t'($urandom_range(SCALED_CHANNELS - 1));
                end else begin
                    chan = chan_t'($urandom_range(31, SCALED_CHANNELS));
                end
                case ($urandom_range(9))
                    0:       sample = '0;
                    1:       sample = '1;
                    default: sample = sample_t'($urandom_range(4095));
                endcase
            end
            send_sample(chan, sample, blank);
        end
        steady = 1'b0;
        drain_readings();
        repeat (PIPE_LATENCY * 4) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
